@@ rtl/adpa_pkg.sv @@
`default_nettype none
package adpa_pkg;

	localparam int unsigned WordBits = 32;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} alu_op_t;

	typedef enum logic [1:0] {
		SHIFT_LSL = 2'd0,
		SHIFT_LSR = 2'd1,
		SHIFT_ASR = 2'd2,
		SHIFT_ROR = 2'd3
	} shift_kind_t;

	// Shifter operand modes. Code 3 is unused and behaves as the rotated immediate.
	localparam logic [1:0] MODE_IMM_AMOUNT = 2'd0;
	localparam logic [1:0] MODE_REG_AMOUNT = 2'd1;
	localparam logic [1:0] MODE_ROT_IMM    = 2'd2;

	typedef struct packed {
		alu_op_t                op;
		logic                   set_flags;
		logic [WordBits-1:0]    a;
		logic [WordBits-1:0]    b;
		shift_kind_t            kind;
		logic [7:0]             amount;
		logic [1:0]             mode;
		logic                   n;
		logic                   z;
		logic                   c;
		logic                   v;
	} req_t;

	typedef struct packed {
		logic [WordBits-1:0]    value;
		logic                   carry;
	} shift_out_t;

	typedef struct packed {
		logic [WordBits-1:0]    result;
		logic                   writes_destination;
		logic                   n;
		logic                   z;
		logic                   c;
		logic                   v;
	} rsp_t;

endpackage
`default_nettype wire

@@ rtl/arm_data_processing_alu.sv @@
`default_nettype none
// Data-processing ALU of a 32-bit ARMv4-style core with its barrel shifter.
// An accepted beat is held in an input register; the shifter and the ALU
// work on it combinationally and the outcome lands in a result register,
// which presents it; the block takes one beat in every cycle while the
// result register keeps moving on out_ready. The shifter followed by the 32-bit
// adder and the flag logic is the path between the two registers. in_ready
// stays high while the input register is empty or can move on to the result
// register; while a result waits on out_ready, a beat enters only if it is empty.
module arm_data_processing_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  operation,
	input  wire logic        set_flags,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	input  wire logic [1:0]  shift_kind,
	input  wire logic [7:0]  shift_amount,
	input  wire logic [1:0]  shifter_mode,
	input  wire logic        flag_n_in,
	input  wire logic        flag_z_in,
	input  wire logic        flag_c_in,
	input  wire logic        flag_v_in,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result,
	output logic             writes_destination,
	output logic             flag_n_out,
	output logic             flag_z_out,
	output logic             flag_c_out,
	output logic             flag_v_out
);

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 ready_s2;
	adpa_pkg::req_t       req_s1;
	adpa_pkg::rsp_t       rsp_s2;
	adpa_pkg::rsp_t       rsp_d;
	adpa_pkg::shift_out_t sh;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.op        <= adpa_pkg::alu_op_t'(operation);
			req_s1.set_flags <= set_flags;
			req_s1.a         <= operand_a;
			req_s1.b         <= operand_b;
			req_s1.kind      <= adpa_pkg::shift_kind_t'(shift_kind);
			req_s1.amount    <= shift_amount;
			req_s1.mode      <= shifter_mode;
			req_s1.n         <= flag_n_in;
			req_s1.z         <= flag_z_in;
			req_s1.c         <= flag_c_in;
			req_s1.v         <= flag_v_in;
		end
		if (valid_s1 && ready_s2) rsp_s2 <= rsp_d;
	end

	adpa_shifter u_shifter (
		.b      (req_s1.b),
		.kind   (req_s1.kind),
		.amount (req_s1.amount),
		.mode   (req_s1.mode),
		.cin    (req_s1.c),
		.sh     (sh)
	);

	always_comb begin
		logic [31:0] x;
		logic [31:0] y;
		logic        ci;
		logic        arith;
		logic        is_test;
		logic [31:0] logic_r;
		logic [32:0] sum;
		logic [31:0] r;
		logic        ovf;

		x       = req_s1.a;
		y       = sh.value;
		ci      = 1'b0;
		arith   = 1'b0;
		is_test = 1'b0;
		logic_r = 32'd0;
		unique case (req_s1.op)
			adpa_pkg::OP_AND: logic_r = req_s1.a & sh.value;
			adpa_pkg::OP_EOR: logic_r = req_s1.a ^ sh.value;
			adpa_pkg::OP_SUB: begin
				y = ~sh.value; ci = 1'b1; arith = 1'b1;
			end
			adpa_pkg::OP_RSB: begin
				x = sh.value; y = ~req_s1.a; ci = 1'b1; arith = 1'b1;
			end
			adpa_pkg::OP_ADD: arith = 1'b1;
			adpa_pkg::OP_ADC: begin
				ci = req_s1.c; arith = 1'b1;
			end
			adpa_pkg::OP_SBC: begin
				y = ~sh.value; ci = req_s1.c; arith = 1'b1;
			end
			adpa_pkg::OP_RSC: begin
				x = sh.value; y = ~req_s1.a; ci = req_s1.c; arith = 1'b1;
			end
			adpa_pkg::OP_TST: begin
				logic_r = req_s1.a & sh.value; is_test = 1'b1;
			end
			adpa_pkg::OP_TEQ: begin
				logic_r = req_s1.a ^ sh.value; is_test = 1'b1;
			end
			adpa_pkg::OP_CMP: begin
				y = ~sh.value; ci = 1'b1; arith = 1'b1; is_test = 1'b1;
			end
			adpa_pkg::OP_CMN: begin
				arith = 1'b1; is_test = 1'b1;
			end
			adpa_pkg::OP_ORR: logic_r = req_s1.a | sh.value;
			adpa_pkg::OP_MOV: logic_r = sh.value;
			adpa_pkg::OP_BIC: logic_r = req_s1.a & ~sh.value;
			adpa_pkg::OP_MVN: logic_r = ~sh.value;
		endcase

		sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
		r   = arith ? sum[31:0] : logic_r;
		ovf = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);

		rsp_d.result             = r;
		rsp_d.writes_destination = !is_test;
		rsp_d.n                  = req_s1.n;
		rsp_d.z                  = req_s1.z;
		rsp_d.c                  = req_s1.c;
		rsp_d.v                  = req_s1.v;
		if (req_s1.set_flags || is_test) begin
			rsp_d.n = r[31];
			rsp_d.z = (r == 32'd0);
			// Logical operations take C from the shifter and keep V.
			if (arith) begin
				rsp_d.c = sum[32];
				rsp_d.v = ovf;
			end else begin
				rsp_d.c = sh.carry;
			end
		end
	end

	assign out_valid          = valid_s2;
	assign result             = rsp_s2.result;
	assign writes_destination = rsp_s2.writes_destination;
	assign flag_n_out         = rsp_s2.n;
	assign flag_z_out         = rsp_s2.z;
	assign flag_c_out         = rsp_s2.c;
	assign flag_v_out         = rsp_s2.v;

endmodule
`default_nettype wire

@@ rtl/adpa_shifter.sv @@
`default_nettype none
module adpa_shifter (
	input  wire logic [31:0]           b,
	input  wire adpa_pkg::shift_kind_t kind,
	input  wire logic [7:0]            amount,
	input  wire logic [1:0]            mode,
	input  wire logic                  cin,
	output adpa_pkg::shift_out_t       sh
);

	always_comb begin
		logic [31:0]        imm;
		logic [63:0]        rot_imm;
		logic [63:0]        rot_b;
		logic [7:0]         amt;
		logic [32:0]        lsl_w;
		logic [32:0]        lsr_w;
		logic signed [32:0] asr_w;
		logic [31:0]        fill;
		logic               big;
		logic               eq32;

		imm     = {24'd0, b[7:0]};
		rot_imm = {imm, imm} >> amount[4:0];
		rot_b   = {b, b} >> amount[4:0];
		amt     = (mode == adpa_pkg::MODE_IMM_AMOUNT) ? {3'd0, amount[4:0]} : amount;
		// The extra bit on each shift catches the last bit shifted out as carry.
		lsl_w   = {1'b0, b} << amt[4:0];
		lsr_w   = {b, 1'b0} >> amt[4:0];
		asr_w   = $signed({b, 1'b0}) >>> amt[4:0];
		fill    = {32{b[31]}};
		big     = (amt[7:5] != 3'd0);
		eq32    = (amt == 8'd32);

		sh.value = b;
		sh.carry = cin;
		if (mode[1]) begin
			sh.value = rot_imm[31:0];
			sh.carry = (amount[4:0] == 5'd0) ? cin : rot_imm[31];
		end else if (amt == 8'd0) begin
			if (mode == adpa_pkg::MODE_IMM_AMOUNT) begin
				// A zero immediate count encodes LSR#32, ASR#32 and RRX.
				unique case (kind)
					adpa_pkg::SHIFT_LSL: begin
						sh.value = b;
						sh.carry = cin;
					end
					adpa_pkg::SHIFT_LSR: begin
						sh.value = 32'd0;
						sh.carry = b[31];
					end
					adpa_pkg::SHIFT_ASR: begin
						sh.value = fill;
						sh.carry = b[31];
					end
					adpa_pkg::SHIFT_ROR: begin
						sh.value = {cin, b[31:1]};
						sh.carry = b[0];
					end
				endcase
			end else begin
				sh.value = b;
				sh.carry = cin;
			end
		end else begin
			unique case (kind)
				adpa_pkg::SHIFT_LSL: begin
					if (!big) begin
						sh.value = lsl_w[31:0];
						sh.carry = lsl_w[32];
					end else begin
						sh.value = 32'd0;
						sh.carry = eq32 & b[0];
					end
				end
				adpa_pkg::SHIFT_LSR: begin
					if (!big) begin
						sh.value = lsr_w[32:1];
						sh.carry = lsr_w[0];
					end else begin
						sh.value = 32'd0;
						sh.carry = eq32 & b[31];
					end
				end
				adpa_pkg::SHIFT_ASR: begin
					if (!big) begin
						sh.value = asr_w[32:1];
						sh.carry = asr_w[0];
					end else begin
						sh.value = fill;
						sh.carry = b[31];
					end
				end
				adpa_pkg::SHIFT_ROR: begin
					if (amt[4:0] == 5'd0) begin
						sh.value = b;
						sh.carry = b[31];
					end else begin
						sh.value = rot_b[31:0];
						sh.carry = rot_b[31];
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ tb/arm_data_processing_alu_tb.sv @@
`timescale 1ns / 1ps
module arm_data_processing_alu_tb;
	import adpa_pkg::*;

	// Shifter mode code 3 has no name in the package; it acts as the rotated immediate.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned RANDOM_OPS = 450;

	class alu_scoreboard;
		rsp_t        awaited_results[$];
		int unsigned results_checked;
		int unsigned field_errors;

		function logic [31:0] rotate_right(logic [31:0] v, int unsigned n);
			int unsigned k;
			k = n % 32;
			if (k == 0)
				return v;
			return (v >> k) | (v << (32 - k));
		endfunction

		function shift_out_t barrel_shift(req_t r);
			logic [31:0] b;
			logic [31:0] fill;
			logic        sign;
			int unsigned amt;
			shift_out_t  s;
			b = r.b;
			sign = b[31];
			fill = {32{sign}};
			if (r.mode != MODE_IMM_AMOUNT && r.mode != MODE_REG_AMOUNT) begin
				amt = 32'(r.amount[4:0]);
				s.value = rotate_right({24'd0, b[7:0]}, amt);
				s.carry = (amt == 0) ? r.c : s.value[31];
				return s;
			end
			if (r.mode == MODE_IMM_AMOUNT) begin
				amt = 32'(r.amount[4:0]);
				// A zero immediate count encodes LSL#0, LSR#32, ASR#32 or RRX.
				if (amt == 0) begin
					case (r.kind)
						SHIFT_LSL: begin
							s.value = b;
							s.carry = r.c;
						end
						SHIFT_LSR: begin
							s.value = 32'd0;
							s.carry = sign;
						end
						SHIFT_ASR: begin
							s.value = fill;
							s.carry = sign;
						end
						default: begin
							s.value = {r.c, b[31:1]};
							s.carry = b[0];
						end
					endcase
					return s;
				end
			end else begin
				amt = 32'(r.amount);
				if (amt == 0) begin
					s.value = b;
					s.carry = r.c;
					return s;
				end
			end
			case (r.kind)
				SHIFT_LSL: begin
					if (amt < 32) begin
						s.carry = b[32 - amt];
						s.value = b << amt;
					end else begin
						s.carry = (amt == 32) ? b[0] : 1'b0;
						s.value = 32'd0;
					end
				end
				SHIFT_LSR: begin
					if (amt < 32) begin
						s.carry = b[amt - 1];
						s.value = b >> amt;
					end else begin
						s.carry = (amt == 32) ? sign : 1'b0;
						s.value = 32'd0;
					end
				end
				SHIFT_ASR: begin
					if (amt < 32) begin
						s.carry = b[amt - 1];
						s.value = $signed(b) >>> amt;
					end else begin
						s.carry = sign;
						s.value = fill;
					end
				end
				default: begin
					if (amt % 32 == 0) begin
						s.carry = sign;
						s.value = b;
					end else begin
						s.value = rotate_right(b, amt);
						s.carry = s.value[31];
					end
				end
			endcase
			return s;
		endfunction

		function void add_carry(input logic [31:0] x, input logic [31:0] y, input logic cin,
				output logic [31:0] sum, output logic cout, output logic ovf);
			logic [32:0] wide;
			wide = {1'b0, x} + {1'b0, y} + {32'd0, cin};
			sum = wide[31:0];
			cout = wide[32];
			ovf = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
		endfunction

		function rsp_t compute_alu(req_t r);
			shift_out_t  sh;
			logic [31:0] op2;
			logic [31:0] res;
			logic        ac;
			logic        av;
			logic        logical;
			logic        is_test;
			rsp_t        o;
			sh = barrel_shift(r);
			op2 = sh.value;
			ac = r.c;
			av = r.v;
			res = 32'd0;
			logical = 1'b1;
			case (r.op)
				OP_AND, OP_TST: res = r.a & op2;
				OP_EOR, OP_TEQ: res = r.a ^ op2;
				OP_SUB, OP_CMP: add_carry(r.a, ~op2, 1'b1, res, ac, av);
				OP_RSB: add_carry(op2, ~r.a, 1'b1, res, ac, av);
				OP_ADD, OP_CMN: add_carry(r.a, op2, 1'b0, res, ac, av);
				OP_ADC: add_carry(r.a, op2, r.c, res, ac, av);
				OP_SBC: add_carry(r.a, ~op2, r.c, res, ac, av);
				OP_RSC: add_carry(op2, ~r.a, r.c, res, ac, av);
				OP_ORR: res = r.a | op2;
				OP_MOV: res = op2;
				OP_BIC: res = r.a & ~op2;
				default: res = ~op2;
			endcase
			if (r.op inside {OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC, OP_CMP, OP_CMN})
				logical = 1'b0;
			is_test = r.op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
			o.result = res;
			o.writes_destination = !is_test;
			o.n = r.n;
			o.z = r.z;
			o.c = r.c;
			o.v = r.v;
			if (r.set_flags || is_test) begin
				o.n = res[31];
				o.z = (res == 32'd0);
				if (logical) begin
					o.c = sh.carry;
				end else begin
					o.c = ac;
					o.v = av;
				end
			end
			return o;
		endfunction

		function void note_operation(req_t r);
			awaited_results.push_back(compute_alu(r));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				field_errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited_results.size() == 0) begin
				field_errors++;
				$display("%0t: result beat with nothing expected, expected none, actual %h",
					$time, got.result);
				return;
			end
			want = awaited_results.pop_front();
			results_checked++;
			compare_field("result", want.result, got.result);
			compare_field("writes_destination", 32'(want.writes_destination),
				32'(got.writes_destination));
			compare_field("flag_n_out", 32'(want.n), 32'(got.n));
			compare_field("flag_z_out", 32'(want.z), 32'(got.z));
			compare_field("flag_c_out", 32'(want.c), 32'(got.c));
			compare_field("flag_v_out", 32'(want.v), 32'(got.v));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  operation = 4'd0;
	logic        set_flags = 1'b0;
	logic [31:0] operand_a = 32'd0;
	logic [31:0] operand_b = 32'd0;
	logic [1:0]  shift_kind = 2'd0;
	logic [7:0]  shift_amount = 8'd0;
	logic [1:0]  shifter_mode = 2'd0;
	logic        flag_n_in = 1'b0;
	logic        flag_z_in = 1'b0;
	logic        flag_c_in = 1'b0;
	logic        flag_v_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result;
	logic        writes_destination;
	logic        flag_n_out;
	logic        flag_z_out;
	logic        flag_c_out;
	logic        flag_v_out;

	alu_scoreboard sb;
	int unsigned   idle_pct = 11;
	int unsigned   ops_issued = 0;
	int unsigned   quiet_cycles = 0;

	arm_data_processing_alu DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.set_flags(set_flags),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.shift_kind(shift_kind),
		.shift_amount(shift_amount),
		.shifter_mode(shifter_mode),
		.flag_n_in(flag_n_in),
		.flag_z_in(flag_z_in),
		.flag_c_in(flag_c_in),
		.flag_v_in(flag_v_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(result),
		.writes_destination(writes_destination),
		.flag_n_out(flag_n_out),
		.flag_z_out(flag_z_out),
		.flag_c_out(flag_c_out),
		.flag_v_out(flag_v_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{result, writes_destination, flag_n_out, flag_z_out,
				flag_c_out, flag_v_out});
	end

	// Ends a hung run: no beat moved on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles without a beat", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic req_t make_op(alu_op_t op, logic s, logic [31:0] a, logic [31:0] b,
			shift_kind_t k, logic [7:0] amt, logic [1:0] mode, logic [3:0] nzcv);
		req_t r;
		r.op = op;
		r.set_flags = s;
		r.a = a;
		r.b = b;
		r.kind = k;
		r.amount = amt;
		r.mode = mode;
		{r.n, r.z, r.c, r.v} = nzcv;
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_amount();
		logic [7:0] v;
		v = 8'($urandom_range(255));
		case ($urandom_range(5))
			0: return 8'd0;
			1: return {v[7:5], 5'd0};
			2: return 8'd31 + 8'($urandom_range(2));
			default: return v;
		endcase
	endfunction

	function automatic req_t random_op();
		return make_op(alu_op_t'($urandom_range(15)), 1'($urandom_range(1)), pick_word(),
			pick_word(), shift_kind_t'($urandom_range(3)), pick_amount(),
			2'($urandom_range(3)), 4'($urandom_range(15)));
	endfunction

	task automatic drive_op(input req_t r);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		operation = r.op;
		set_flags = r.set_flags;
		operand_a = r.a;
		operand_b = r.b;
		shift_kind = r.kind;
		shift_amount = r.amount;
		shifter_mode = r.mode;
		{flag_n_in, flag_z_in, flag_c_in, flag_v_in} = {r.n, r.z, r.c, r.v};
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_operation(r);
		ops_issued++;
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every opcode at least once, together with the shifter's special encodings and edges.
		drive_op(make_op(OP_AND, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SHIFT_LSL, 8'd0,
			MODE_IMM_AMOUNT, 4'b0000));
		drive_op(make_op(OP_EOR, 1'b1, 32'h0000_0000, 32'h8000_0000, SHIFT_LSR, 8'd0,
			MODE_IMM_AMOUNT, 4'b1111));
		drive_op(make_op(OP_SUB, 1'b1, 32'h0000_0000, 32'h8000_0000, SHIFT_ASR, 8'd0,
			MODE_IMM_AMOUNT, 4'b0000));
		drive_op(make_op(OP_RSB, 1'b1, 32'h0000_0001, 32'h0000_0001, SHIFT_ROR, 8'd0,
			MODE_IMM_AMOUNT, 4'b0010));
		drive_op(make_op(OP_ADD, 1'b1, 32'h7FFF_FFFF, 32'h0000_0001, SHIFT_LSL, 8'd0,
			MODE_IMM_AMOUNT, 4'b0000));
		drive_op(make_op(OP_ADC, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, SHIFT_LSL, 8'd0,
			MODE_REG_AMOUNT, 4'b0010));
		drive_op(make_op(OP_SBC, 1'b1, 32'h8000_0000, 32'h0000_0001, SHIFT_LSL, 8'd32,
			MODE_REG_AMOUNT, 4'b0000));
		drive_op(make_op(OP_RSC, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, SHIFT_LSL, 8'd33,
			MODE_REG_AMOUNT, 4'b0001));
		drive_op(make_op(OP_TST, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000, SHIFT_LSR, 8'd32,
			MODE_REG_AMOUNT, 4'b0101));
		drive_op(make_op(OP_TEQ, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, SHIFT_LSR, 8'd255,
			MODE_REG_AMOUNT, 4'b1010));
		drive_op(make_op(OP_CMP, 1'b0, 32'h0000_0000, 32'h8000_0000, SHIFT_ASR, 8'd200,
			MODE_REG_AMOUNT, 4'b0000));
		drive_op(make_op(OP_CMN, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, SHIFT_ASR, 8'd32,
			MODE_REG_AMOUNT, 4'b1111));
		drive_op(make_op(OP_ORR, 1'b1, 32'h0000_0000, 32'h8000_0001, SHIFT_ROR, 8'd64,
			MODE_REG_AMOUNT, 4'b0000));
		drive_op(make_op(OP_MOV, 1'b1, 32'h0000_0000, 32'h1234_5678, SHIFT_ROR, 8'd32,
			MODE_REG_AMOUNT, 4'b0010));
		drive_op(make_op(OP_BIC, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SHIFT_ROR, 8'd0,
			MODE_ROT_IMM, 4'b0010));
		drive_op(make_op(OP_MVN, 1'b1, 32'h0000_0000, 32'hFFFF_FF80, SHIFT_LSL, 8'd1,
			MODE_ROT_IMM, 4'b0000));
		drive_op(make_op(OP_MOV, 1'b1, 32'h0000_0000, 32'h0000_00FF, SHIFT_ASR, 8'd8,
			MODE_UNUSED, 4'b0000));
		drive_op(make_op(OP_MOV, 1'b0, 32'h0000_0000, 32'h0000_00A5, SHIFT_LSR, 8'd255,
			MODE_ROT_IMM, 4'b1010));
		drive_op(make_op(OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'h0000_0001, SHIFT_LSL, 8'd1,
			MODE_IMM_AMOUNT, 4'b0101));
		drive_op(make_op(OP_SUB, 1'b1, 32'h0000_0005, 32'h0000_0005, SHIFT_LSL, 8'd0,
			MODE_IMM_AMOUNT, 4'b1001));
		drive_op(make_op(OP_MOV, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, SHIFT_LSL, 8'd255,
			MODE_IMM_AMOUNT, 4'b0000));
		drive_op(make_op(OP_MOV, 1'b1, 32'h0000_0000, 32'h8000_0000, SHIFT_ASR, 8'd31,
			MODE_IMM_AMOUNT, 4'b0000));
		drive_op(make_op(OP_MOV, 1'b1, 32'h0000_0000, 32'h8000_0000, SHIFT_LSR, 8'd31,
			MODE_REG_AMOUNT, 4'b0000));
		drive_op(make_op(OP_ADC, 1'b1, 32'h0000_0000, 32'h0000_0000, SHIFT_LSL, 8'd255,
			MODE_REG_AMOUNT, 4'b0010));

		for (int i = 0; i < RANDOM_OPS; i++) begin
			// A stretch of back-to-back beats with the receiver never stalling.
			idle_pct = (i >= 100 && i < 220) ? 0 : 11;
			drive_op(random_op());
		end
		idle_pct = 11;
		@(negedge clk);
		in_valid = 1'b0;

		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d operations: all 16 opcodes, every shifter mode and the",
			ops_issued);
		$display("special shift encodings; %0d results checked, %0d field mismatches",
			sb.results_checked, sb.field_errors);
		if (sb.field_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
